// ===== src/icseq_pkg.sv =====
// ============================================================================
// Irrigation cycle sequencer package
// Shared payload types, command and relay codes, register indexes and sizes.
// ============================================================================
package icseq_pkg;

   // Fixed field widths of the request and response items.
   localparam int COMMAND_W   = 3;
   localparam int MOISTURE_W  = 10;
   localparam int RELAY_W     = 2;
   localparam int INTERVAL_W  = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   // Interval in seconds; 2047 minutes times 60 still fits in 17 bits.
   localparam int INTERVAL_SEC_W = 17;

   // Number of low bits of each moisture sample that are significant.
   localparam int MOISTURE_BITS = 10;

   // Valve open time that ends a watering cycle, and the valve timer size.
   localparam int DURATION_SECONDS = 30;
   localparam int VALVE_W          = 8;

   // Default width of the two seconds counters.
   localparam int COUNTER_BITS_DEFAULT = 17;

   // Register reset values.
   localparam logic [MOISTURE_W-1:0] THRESHOLD_RESET = '0;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET  = INTERVAL_W'(60);

   // Commands.
   localparam logic [COMMAND_W-1:0] CMD_TICK     = 3'd0;
   localparam logic [COMMAND_W-1:0] CMD_CHECK    = 3'd1;
   localparam logic [COMMAND_W-1:0] CMD_PROGRESS = 3'd2;
   localparam logic [COMMAND_W-1:0] CMD_MANUAL   = 3'd3;
   localparam logic [COMMAND_W-1:0] CMD_STOP     = 3'd4;

   // Relay requests.
   localparam logic [RELAY_W-1:0] RELAY_NONE = 2'd0;
   localparam logic [RELAY_W-1:0] RELAY_ON   = 2'd1;
   localparam logic [RELAY_W-1:0] RELAY_OFF  = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUTO      = 2'd2;

   typedef struct packed {
      logic [COMMAND_W-1:0]  command;
      logic [MOISTURE_W-1:0] moisture_a;
      logic [MOISTURE_W-1:0] moisture_b;
      logic [MOISTURE_W-1:0] moisture_c;
      logic                  relay_confirmed;
      logic                  overflow_near;
      logic                  manual_value;
   } req_type;

   typedef struct packed {
      logic [RELAY_W-1:0]    relay_request;
      logic                  notify;
      logic [MOISTURE_W-1:0] notify_moisture;
      logic                  watering_active;
      logic                  valve_open;
      logic                  cycle_finished;
      logic                  manual_cleared;
   } rsp_type;

   // Configuration as seen by the sequencing logic.
   typedef struct packed {
      logic [MOISTURE_W-1:0]     moisture_threshold;
      logic [INTERVAL_SEC_W-1:0] interval_seconds;
      logic                      auto_enable;
   } cfg_type;

endpackage

// ===== src/icseq_csr.sv =====
// ============================================================================
// Irrigation cycle sequencer configuration registers
// Holds threshold, interval and enable; keeps the interval in seconds.
// ============================================================================
module icseq_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [icseq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [icseq_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output icseq_pkg::cfg_type                  cfg
);
   import icseq_pkg::*;

   logic [MOISTURE_W-1:0]     threshold_ff, threshold_in;
   logic [INTERVAL_SEC_W-1:0] interval_sec_ff, interval_sec_in;
   logic                      auto_enable_ff, auto_enable_in;
   logic [INTERVAL_SEC_W-1:0] minutes_wide;

   // Minutes times 60 as 64x minus 4x, worked out once at the write.
   assign minutes_wide = INTERVAL_SEC_W'(csr_wdata[INTERVAL_W-1:0]);

   always_comb begin
      threshold_in    = threshold_ff;
      interval_sec_in = interval_sec_ff;
      auto_enable_in  = auto_enable_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_in = csr_wdata[MOISTURE_W-1:0];
            CSR_INTERVAL:  interval_sec_in = (minutes_wide << 6) - (minutes_wide << 2);
            CSR_AUTO:      auto_enable_in = csr_wdata[0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_RESET;
         interval_sec_ff <= (INTERVAL_SEC_W'(INTERVAL_RESET) << 6)
                            - (INTERVAL_SEC_W'(INTERVAL_RESET) << 2);
         auto_enable_ff  <= 1'b0;
      end else begin
         threshold_ff    <= threshold_in;
         interval_sec_ff <= interval_sec_in;
         auto_enable_ff  <= auto_enable_in;
      end
   end

   assign cfg.moisture_threshold = threshold_ff;
   assign cfg.interval_seconds   = interval_sec_ff;
   assign cfg.auto_enable        = auto_enable_ff;

endmodule

// ===== src/icseq_core.sv =====
// ============================================================================
// Irrigation cycle sequencer core
// Cycle state, seconds counters and the per-command decision logic.
// ============================================================================
module icseq_core #(
   parameter int COUNTER_BITS = icseq_pkg::COUNTER_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  icseq_pkg::cfg_type  cfg,
   input  icseq_pkg::req_type  item,
   input  logic                advance,
   output icseq_pkg::rsp_type  result
);
   import icseq_pkg::*;

   localparam logic [MOISTURE_W-1:0] MOISTURE_MASK = MOISTURE_W'((1 << MOISTURE_BITS) - 1);
   localparam logic [VALVE_W-1:0]    DURATION      = VALVE_W'(DURATION_SECONDS);

   logic                    cycle_started_ff, cycle_started_in;
   logic                    valve_open_ff, valve_open_in;
   logic                    duration_passed_ff, duration_passed_in;
   logic                    manual_request_ff, manual_request_in;
   logic                    ever_watered_ff, ever_watered_in;
   logic [COUNTER_BITS-1:0] since_water_ff, since_water_in;
   logic [VALVE_W-1:0]      valve_sec_ff, valve_sec_in;
   logic                    notice_sent_ff, notice_sent_in;
   logic [COUNTER_BITS-1:0] since_notice_ff, since_notice_in;

   logic [MOISTURE_W-1:0]   samp_a, samp_b, samp_c, max_ab, highest;
   logic [COUNTER_BITS-1:0] need, elapsed;
   logic                    enabled;

   // Highest of the three masked samples.
   assign samp_a  = item.moisture_a & MOISTURE_MASK;
   assign samp_b  = item.moisture_b & MOISTURE_MASK;
   assign samp_c  = item.moisture_c & MOISTURE_MASK;
   assign max_ab  = (samp_a > samp_b) ? samp_a : samp_b;
   assign highest = (samp_c > max_ab) ? samp_c : max_ab;

   // A unit that never watered counts as one full interval elapsed.
   assign need    = COUNTER_BITS'(cfg.interval_seconds);
   assign elapsed = ever_watered_ff ? since_water_ff : need;
   assign enabled = cfg.auto_enable | manual_request_ff;

   // Next state and result for the item in the input register.
   always_comb begin
      logic do_stop;
      logic dur_now;
      do_stop            = 1'b0;
      dur_now            = 1'b0;
      cycle_started_in   = cycle_started_ff;
      valve_open_in      = valve_open_ff;
      duration_passed_in = duration_passed_ff;
      manual_request_in  = manual_request_ff;
      ever_watered_in    = ever_watered_ff;
      since_water_in     = since_water_ff;
      valve_sec_in       = valve_sec_ff;
      notice_sent_in     = notice_sent_ff;
      since_notice_in    = since_notice_ff;
      result             = '0;

      case (item.command)
         CMD_TICK: begin
            if (since_water_ff != '1) since_water_in = since_water_ff + 1'b1;
            if (since_notice_ff != '1) since_notice_in = since_notice_ff + 1'b1;
            if (valve_open_ff && valve_sec_ff != '1) valve_sec_in = valve_sec_ff + 1'b1;
         end
         CMD_CHECK: begin
            if (!item.overflow_near && !cycle_started_ff &&
                highest < cfg.moisture_threshold) begin
               if (enabled) begin
                  if (elapsed >= need) cycle_started_in = 1'b1;
               end else if (!notice_sent_ff || since_notice_ff >= need) begin
                  notice_sent_in         = 1'b1;
                  since_notice_in        = '0;
                  result.notify          = 1'b1;
                  result.notify_moisture = highest;
               end
            end
         end
         CMD_PROGRESS: begin
            if (cycle_started_ff && item.overflow_near) begin
               do_stop = 1'b1;
            end else if (enabled && cycle_started_ff) begin
               dur_now = valve_open_ff && valve_sec_ff >= DURATION;
               if (!dur_now && !valve_open_ff) begin
                  if (item.relay_confirmed) begin
                     valve_open_in = 1'b1;
                     valve_sec_in  = '0;
                  end else begin
                     result.relay_request = RELAY_ON;
                  end
               end
               do_stop = dur_now | duration_passed_ff;
            end
         end
         CMD_MANUAL: begin
            manual_request_in = item.manual_value;
         end
         CMD_STOP: begin
            do_stop = 1'b1;
         end
         default: ;
      endcase

      // Stopping ends the cycle; a running cycle also records the watering.
      if (do_stop) begin
         if (cycle_started_ff) begin
            result.relay_request  = RELAY_OFF;
            result.cycle_finished = 1'b1;
            since_water_in        = '0;
            ever_watered_in       = 1'b1;
            if (manual_request_ff) begin
               manual_request_in     = 1'b0;
               result.manual_cleared = 1'b1;
            end
         end
         valve_open_in      = 1'b0;
         cycle_started_in   = 1'b0;
         duration_passed_in = 1'b0;
         valve_sec_in       = '0;
      end

      result.watering_active = cycle_started_in;
      result.valve_open      = valve_open_in;
   end

   // State moves only when the item passes into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_started_ff   <= 1'b0;
         valve_open_ff      <= 1'b0;
         duration_passed_ff <= 1'b0;
         manual_request_ff  <= 1'b0;
         ever_watered_ff    <= 1'b0;
         since_water_ff     <= '0;
         valve_sec_ff       <= '0;
         notice_sent_ff     <= 1'b0;
         since_notice_ff    <= '0;
      end else if (advance) begin
         cycle_started_ff   <= cycle_started_in;
         valve_open_ff      <= valve_open_in;
         duration_passed_ff <= duration_passed_in;
         manual_request_ff  <= manual_request_in;
         ever_watered_ff    <= ever_watered_in;
         since_water_ff     <= since_water_in;
         valve_sec_ff       <= valve_sec_in;
         notice_sent_ff     <= notice_sent_in;
         since_notice_ff    <= since_notice_in;
      end
   end

endmodule

// ===== src/irrigation_cycle_sequencer.sv =====
// ============================================================================
// Irrigation cycle sequencer
// Top level: input register, sequencing core, result register, config port.
// ============================================================================
// The sequencer takes one command per clock unless the result side stalls, and
// returns exactly one result per command. A command sits in the input register
// while the core decides it against the current cycle state, and the result
// then moves into the result register once that register is free or drained.
// The state is updated as the command moves into the result register, so
// commands may follow each other in every cycle; a stalled result holds the
// input side only once both registers are full. The user writes registers
// through the csr_ port only while no command is in flight; the block itself
// does not enforce this.
module irrigation_cycle_sequencer #(
   parameter int COUNTER_BITS = icseq_pkg::COUNTER_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  icseq_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output icseq_pkg::rsp_type                rsp_data,
   input  logic                              csr_we,
   input  logic [icseq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [icseq_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import icseq_pkg::*;

   cfg_type cfg;
   req_type item_ff, item_in;
   logic    item_valid_ff, item_valid_in;
   rsp_type result;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    advance;

   icseq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   icseq_core #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (item_ff),
      .advance (advance),
      .result  (result)
   );

   // The held command moves on when the result register is free or drained.
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (req_ready) begin
         item_in       = req_data;
         item_valid_in = req_valid;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/icseq_checker.sv =====
// ============================================================================
// Irrigation cycle sequencer checker
// Port-level checks on the result channel, bound to the top level.
// ============================================================================
module icseq_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input icseq_pkg::rsp_type rsp_data
);
   import icseq_pkg::*;

   // A stalled result stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // The valve is only reported open inside a running cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.valve_open |-> rsp_data.watering_active)
      else $error("valve open without an active cycle");

   // A finished cycle switches the relay off and leaves everything idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.cycle_finished || rsp_data.manual_cleared) |->
         rsp_data.cycle_finished && rsp_data.relay_request == RELAY_OFF &&
         !rsp_data.watering_active && !rsp_data.valve_open)
      else $error("inconsistent cycle stop result");

   // A moisture reading is reported only together with a notice.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.notify |-> rsp_data.notify_moisture == '0)
      else $error("moisture reported without a notice");

endmodule

bind irrigation_cycle_sequencer icseq_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== sim/tb_top.sv =====
// ============================================================================
// Irrigation cycle sequencer testbench
// Walks a directed command table, then random watering episodes and noise
// under several register settings, and ends with a burst of back-to-back
// commands. Each result is compared field by field with the expected result
// given in the table or else with the prediction of an independent model.
// ============================================================================
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import icseq_pkg::*;

   localparam int CNT_W           = COUNTER_BITS_DEFAULT;
   localparam int SECS_PER_MIN    = 60;
   localparam int CYCLE_LIMIT     = 1_500_000;
   localparam int PHASE_ITEMS     = 180;
   localparam int PHASE_COUNT     = 5;
   localparam int BURST_ITEMS     = 40;
   localparam int REPORT_LIMIT    = 100;
   localparam logic [COMMAND_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [COMMAND_W-1:0] CMD_SPARE_HI = 3'd7;
   localparam rsp_type QUIET = '0;

   typedef enum logic {ROW_ITEM, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      req_type                item;
      logic [15:0]            count;
      logic                   typed;
      rsp_type                want;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  value;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Predicted register contents.
   logic [MOISTURE_W-1:0] thr_cfg      = THRESHOLD_RESET;
   logic [INTERVAL_W-1:0] interval_cfg = INTERVAL_RESET;
   logic                  auto_cfg     = 1'b0;

   // Predicted sequencer state.
   logic             running          = 1'b0;
   logic             valve_on         = 1'b0;
   logic             duration_done    = 1'b0;
   logic             manual_req       = 1'b0;
   logic             watered_once     = 1'b0;
   logic             notice_out       = 1'b0;
   logic [CNT_W-1:0] secs_since_water = '0;
   logic [CNT_W-1:0] secs_since_notice = '0;
   logic [VALVE_W-1:0] valve_secs     = '0;

   rsp_type      pending_outcomes[$];
   stim_row_type stim_rows[$];
   int           fault_count = 0;
   int           items_sent  = 0;
   logic         steady      = 1'b0;

   // Register settings of the random phases; the threshold extremes are among them.
   logic [MOISTURE_W-1:0] phase_thr  [PHASE_COUNT] = '{512, 1023, 0, 700, 300};
   logic [INTERVAL_W-1:0] phase_ivl  [PHASE_COUNT] = '{0, 1, 0, 1440, 0};
   logic                  phase_auto [PHASE_COUNT] = '{1, 0, 1, 1, 0};

   irrigation_cycle_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A running cycle ends: relay off, watering time recorded, manual flag dropped.
   function automatic void close_cycle(inout rsp_type o);
      if (running) begin
         o.relay_request = RELAY_OFF;
         secs_since_water = '0;
         watered_once = 1'b1;
         o.cycle_finished = 1'b1;
         if (manual_req) begin
            manual_req = 1'b0;
            o.manual_cleared = 1'b1;
         end
      end
      valve_on = 1'b0;
      running = 1'b0;
      duration_done = 1'b0;
      valve_secs = '0;
   endfunction

   // Advances the predicted state by one command and returns its result.
   function automatic rsp_type predict_watering(input req_type r);
      rsp_type               o;
      logic [MOISTURE_W-1:0] peak;
      logic [CNT_W-1:0]      need;
      logic [CNT_W-1:0]      elapsed;
      logic                  enabled;
      o = '0;
      need = CNT_W'(interval_cfg * SECS_PER_MIN);
      enabled = auto_cfg || manual_req;
      case (r.command)
         CMD_TICK: begin
            if (secs_since_water != '1) secs_since_water = secs_since_water + 1'b1;
            if (secs_since_notice != '1) secs_since_notice = secs_since_notice + 1'b1;
            if (valve_on && valve_secs != '1) valve_secs = valve_secs + 1'b1;
         end
         CMD_CHECK: begin
            if (!r.overflow_near && !running) begin
               peak = (r.moisture_a > r.moisture_b) ? r.moisture_a : r.moisture_b;
               if (r.moisture_c > peak) peak = r.moisture_c;
               // Before the first watering the full interval counts as elapsed.
               elapsed = watered_once ? secs_since_water : need;
               if (peak < thr_cfg) begin
                  if (enabled) begin
                     if (elapsed >= need) running = 1'b1;
                  end else if (!notice_out || secs_since_notice >= need) begin
                     notice_out = 1'b1;
                     secs_since_notice = '0;
                     o.notify = 1'b1;
                     o.notify_moisture = peak;
                  end
               end
            end
         end
         CMD_PROGRESS: begin
            if (running && r.overflow_near) begin
               close_cycle(o);
            end else if (enabled && running) begin
               if (valve_on && valve_secs >= DURATION_SECONDS) begin
                  duration_done = 1'b1;
               end else if (!valve_on && r.relay_confirmed) begin
                  valve_on = 1'b1;
                  valve_secs = '0;
               end else if (!valve_on) begin
                  o.relay_request = RELAY_ON;
               end
               if (duration_done) close_cycle(o);
            end
         end
         CMD_MANUAL: manual_req = r.manual_value;
         CMD_STOP: close_cycle(o);
         default: ;
      endcase
      o.watering_active = running;
      o.valve_open = valve_on;
      return o;
   endfunction

   function automatic req_type cmd_item(input logic [COMMAND_W-1:0] cmd,
                                        input logic [MOISTURE_W-1:0] a,
                                        input logic [MOISTURE_W-1:0] b,
                                        input logic [MOISTURE_W-1:0] c,
                                        input logic rc, input logic ov,
                                        input logic mv);
      req_type r;
      r.command = cmd;
      r.moisture_a = a;
      r.moisture_b = b;
      r.moisture_c = c;
      r.relay_confirmed = rc;
      r.overflow_near = ov;
      r.manual_value = mv;
      return r;
   endfunction

   function automatic rsp_type outcome(input logic [RELAY_W-1:0] relay, input logic nt,
                                       input logic [MOISTURE_W-1:0] nm, input logic wa,
                                       input logic vo, input logic fin, input logic clr);
      rsp_type o;
      o.relay_request = relay;
      o.notify = nt;
      o.notify_moisture = nm;
      o.watering_active = wa;
      o.valve_open = vo;
      o.cycle_finished = fin;
      o.manual_cleared = clr;
      return o;
   endfunction

   function automatic void add_item(input req_type r, input int count, input logic typed,
                                    input rsp_type want);
      stim_row_type row;
      row = '0;
      row.kind = ROW_ITEM;
      row.item = r;
      row.count = 16'(count);
      row.typed = typed;
      row.want = want;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_reg(input logic [CSR_INDEX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] value);
      stim_row_type row;
      row = '0;
      row.kind = ROW_REG;
      row.index = index;
      row.value = value;
      stim_rows.push_back(row);
   endfunction

   function automatic req_type random_item();
      req_type r;
      r.command = COMMAND_W'($urandom);
      r.moisture_a = MOISTURE_W'($urandom);
      r.moisture_b = MOISTURE_W'($urandom);
      r.moisture_c = MOISTURE_W'($urandom);
      r.relay_confirmed = 1'($urandom);
      r.overflow_near = 1'($urandom);
      r.manual_value = 1'($urandom);
      return r;
   endfunction

   // A sample below the current threshold when one exists.
   function automatic logic [MOISTURE_W-1:0] dry_sample();
      if (thr_cfg == '0) return MOISTURE_W'($urandom);
      return MOISTURE_W'($urandom_range(0, int'(thr_cfg) - 1));
   endfunction

   // Sender idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // One request transfer; the expected result is queued at the accepting edge.
   task automatic send_command(input req_type r, input logic typed, input rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predicted = predict_watering(r);
      pending_outcomes.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // Register write once every result in flight has come back.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_THRESHOLD: thr_cfg = value[MOISTURE_W-1:0];
         CSR_INTERVAL: interval_cfg = value[INTERVAL_W-1:0];
         CSR_AUTO: auto_cfg = value[0];
         default: ;
      endcase
   endtask

   // A well-formed watering cycle with random content and occasional disruption.
   task automatic run_episode();
      req_type r;
      int      ticks;
      if ($urandom_range(0, 3) == 0) begin
         r = random_item();
         r.command = CMD_MANUAL;
         send_command(r, 1'b0, QUIET);
      end
      r = random_item();
      r.command = CMD_CHECK;
      r.moisture_a = dry_sample();
      r.moisture_b = dry_sample();
      r.moisture_c = dry_sample();
      r.overflow_near = ($urandom_range(0, 9) == 0);
      send_command(r, 1'b0, QUIET);
      repeat ($urandom_range(0, 2)) begin
         r = random_item();
         r.command = CMD_PROGRESS;
         r.relay_confirmed = 1'b0;
         r.overflow_near = 1'b0;
         send_command(r, 1'b0, QUIET);
      end
      r = random_item();
      r.command = CMD_PROGRESS;
      r.relay_confirmed = 1'b1;
      r.overflow_near = 1'b0;
      send_command(r, 1'b0, QUIET);
      ticks = DURATION_SECONDS + $urandom_range(0, 6);
      repeat (ticks) begin
         r = random_item();
         r.command = CMD_TICK;
         send_command(r, 1'b0, QUIET);
         if ($urandom_range(0, 9) == 0) begin
            r = random_item();
            r.command = CMD_PROGRESS;
            r.overflow_near = ($urandom_range(0, 7) == 0);
            send_command(r, 1'b0, QUIET);
         end else if ($urandom_range(0, 49) == 0) begin
            r = random_item();
            r.command = CMD_STOP;
            send_command(r, 1'b0, QUIET);
         end
      end
      r = random_item();
      r.command = CMD_PROGRESS;
      r.overflow_near = 1'b0;
      send_command(r, 1'b0, QUIET);
   endtask

   // Receiver stalls: ready runs with short, and now and then long, low stretches.
   initial begin : receiver_stalls
      int   run;
      logic level;
      rsp_ready = 1'b0;
      forever begin
         if (steady || $urandom_range(0, 2) != 0) begin
            level = 1'b1;
            run = $urandom_range(1, 16);
         end else begin
            level = 1'b0;
            run = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
         end
         repeat (run) begin
            @(negedge clock);
            rsp_ready <= level;
         end
      end
   end

   task automatic flag_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
      if (got !== want) begin
         fault_count++;
         if (fault_count <= REPORT_LIMIT)
            $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endtask

   // Each response transfer is matched against the oldest expected result.
   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $error("response transfer with no result expected: %p", rsp_data);
         end else begin
            want = pending_outcomes.pop_front();
            flag_field("relay_request", 32'(want.relay_request), 32'(rsp_data.relay_request));
            flag_field("notify", 32'(want.notify), 32'(rsp_data.notify));
            flag_field("notify_moisture", 32'(want.notify_moisture),
                       32'(rsp_data.notify_moisture));
            flag_field("watering_active", 32'(want.watering_active),
                       32'(rsp_data.watering_active));
            flag_field("valve_open", 32'(want.valve_open), 32'(rsp_data.valve_open));
            flag_field("cycle_finished", 32'(want.cycle_finished),
                       32'(rsp_data.cycle_finished));
            flag_field("manual_cleared", 32'(want.manual_cleared),
                       32'(rsp_data.manual_cleared));
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      stim_row_type row;
      int           base;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;

      // Directed table, starting from the reset settings.
      add_item(cmd_item(CMD_TICK, 0, 0, 0, 0, 0, 0), 1, 1, QUIET);
      add_item(cmd_item(CMD_CHECK, 0, 0, 0, 0, 0, 0), 1, 1, QUIET);
      // Stop and progress while idle raise nothing.
      add_item(cmd_item(CMD_STOP, 0, 0, 0, 0, 0, 0), 1, 1, QUIET);
      add_item(cmd_item(CMD_PROGRESS, 0, 0, 0, 1, 0, 0), 1, 1, QUIET);
      // Unused commands leave the state alone.
      add_item(cmd_item(CMD_SPARE_LO, 1023, 1023, 1023, 1, 1, 1), 1, 1, QUIET);
      add_item(cmd_item(CMD_SPARE_HI, 0, 512, 1023, 0, 1, 1), 1, 0, QUIET);
      // Watering disabled: a low reading raises a notice, then it is rate limited.
      add_reg(CSR_THRESHOLD, 11'd1023);
      add_item(cmd_item(CMD_CHECK, 1022, 0, 5, 0, 0, 0), 1, 1,
               outcome(RELAY_NONE, 1, 1022, 0, 0, 0, 0));
      add_item(cmd_item(CMD_CHECK, 1023, 1023, 1023, 0, 0, 0), 1, 1, QUIET);
      add_item(cmd_item(CMD_CHECK, 0, 0, 0, 0, 0, 0), 1, 1, QUIET);
      // With a zero interval every notice passes.
      add_reg(CSR_INTERVAL, 11'd0);
      add_item(cmd_item(CMD_CHECK, 3, 700, 9, 0, 0, 0), 1, 1,
               outcome(RELAY_NONE, 1, 700, 0, 0, 0, 0));
      add_item(cmd_item(CMD_CHECK, 0, 0, 0, 0, 1, 0), 1, 1, QUIET);
      // Manual request with an interval of 1440 minutes and no watering yet.
      add_item(cmd_item(CMD_MANUAL, 0, 0, 0, 0, 0, 1), 1, 1, QUIET);
      add_reg(CSR_INTERVAL, 11'd1440);
      add_item(cmd_item(CMD_CHECK, 0, 0, 1, 0, 0, 0), 1, 1,
               outcome(RELAY_NONE, 0, 0, 1, 0, 0, 0));
      add_item(cmd_item(CMD_PROGRESS, 0, 0, 0, 0, 0, 0), 1, 1,
               outcome(RELAY_ON, 0, 0, 1, 0, 0, 0));
      add_item(cmd_item(CMD_PROGRESS, 0, 0, 0, 1, 0, 0), 1, 1,
               outcome(RELAY_NONE, 0, 0, 1, 1, 0, 0));
      add_item(cmd_item(CMD_PROGRESS, 0, 0, 0, 0, 0, 0), 1, 1,
               outcome(RELAY_NONE, 0, 0, 1, 1, 0, 0));
      add_item(cmd_item(CMD_TICK, 0, 0, 0, 0, 0, 0), DURATION_SECONDS, 1,
               outcome(RELAY_NONE, 0, 0, 1, 1, 0, 0));
      // Duration reached: the same progress ends the cycle and clears manual.
      add_item(cmd_item(CMD_PROGRESS, 0, 0, 0, 0, 0, 0), 1, 1,
               outcome(RELAY_OFF, 0, 0, 0, 0, 1, 1));
      add_reg(CSR_INTERVAL, 11'd0);
      add_reg(CSR_AUTO, 11'd1);
      add_item(cmd_item(CMD_CHECK, 0, 0, 0, 0, 0, 0), 1, 1,
               outcome(RELAY_NONE, 0, 0, 1, 0, 0, 0));
      add_item(cmd_item(CMD_CHECK, 0, 0, 0, 0, 0, 0), 1, 1,
               outcome(RELAY_NONE, 0, 0, 1, 0, 0, 0));
      // Time base near wrap aborts the running cycle.
      add_item(cmd_item(CMD_PROGRESS, 0, 0, 0, 0, 1, 0), 1, 1,
               outcome(RELAY_OFF, 0, 0, 0, 0, 1, 0));
      add_item(cmd_item(CMD_CHECK, 0, 0, 0, 0, 0, 0), 1, 1,
               outcome(RELAY_NONE, 0, 0, 1, 0, 0, 0));
      add_item(cmd_item(CMD_PROGRESS, 0, 0, 0, 1, 0, 0), 1, 1,
               outcome(RELAY_NONE, 0, 0, 1, 1, 0, 0));
      // The valve timer saturates rather than wrapping.
      add_item(cmd_item(CMD_TICK, 0, 0, 0, 0, 0, 0), 260, 1,
               outcome(RELAY_NONE, 0, 0, 1, 1, 0, 0));
      add_item(cmd_item(CMD_PROGRESS, 0, 0, 0, 0, 0, 0), 1, 1,
               outcome(RELAY_OFF, 0, 0, 0, 0, 1, 0));
      // Progress while disabled does nothing to a running cycle.
      add_item(cmd_item(CMD_CHECK, 0, 0, 0, 0, 0, 0), 1, 1,
               outcome(RELAY_NONE, 0, 0, 1, 0, 0, 0));
      add_reg(CSR_AUTO, 11'd0);
      add_item(cmd_item(CMD_PROGRESS, 0, 0, 0, 1, 0, 0), 1, 1,
               outcome(RELAY_NONE, 0, 0, 1, 0, 0, 0));
      add_item(cmd_item(CMD_STOP, 0, 0, 0, 0, 0, 0), 1, 1,
               outcome(RELAY_OFF, 0, 0, 0, 0, 1, 0));
      add_item(cmd_item(CMD_MANUAL, 0, 0, 0, 0, 0, 0), 1, 1, QUIET);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         if (row.kind == ROW_REG) begin
            write_register(row.index, row.value);
         end else begin
            repeat (int'(row.count)) send_command(row.item, row.typed, row.want);
         end
      end

      // Random phases: mostly watering episodes, the rest arbitrary commands.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_register(CSR_THRESHOLD, CSR_DATA_W'(phase_thr[p]));
         write_register(CSR_INTERVAL, CSR_DATA_W'(phase_ivl[p]));
         write_register(CSR_AUTO, CSR_DATA_W'(phase_auto[p]));
         base = items_sent;
         while (items_sent - base < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
               run_episode();
            end else begin
               repeat ($urandom_range(1, 8)) send_command(random_item(), 1'b0, QUIET);
            end
         end
      end

      // Back-to-back burst with no idle cycles on the sending side.
      steady = 1'b1;
      repeat (BURST_ITEMS) send_command(random_item(), 1'b0, QUIET);
      steady = 1'b0;

      // Drain every outstanding result, then idle before the verdict.
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (fault_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== irrigation_cycle_sequencer.f =====
src/icseq_pkg.sv
src/icseq_csr.sv
src/icseq_core.sv
src/irrigation_cycle_sequencer.sv
src/icseq_checker.sv
sim/tb_top.sv
